[rtl/bsbs_pkg.sv]
// Shared constants, types and helpers for the byte stream bit statistics unit.
`default_nettype none
package bsbs_pkg;

  localparam int HIST_DEPTH = 512;
  localparam int HIST_AW    = $clog2(HIST_DEPTH);
  localparam int NUM_SPANS  = 4096;
  localparam int SPAN_AW    = $clog2(NUM_SPANS);
  localparam int MIN_WIDTH  = 3;
  localparam int MAX_WIDTH  = 256;
  localparam int COL_TOTAL  = ((MAX_WIDTH - 1) * MAX_WIDTH) / 2
                            - ((MIN_WIDTH - 1) * MIN_WIDTH) / 2;
  localparam int COL_AW     = $clog2(COL_TOTAL);
  localparam int PH_AW      = $clog2(MAX_WIDTH);
  localparam int STRIDE_W   = 20;

  localparam logic [STRIDE_W-1:0] WIDE_STRIDE = STRIDE_W'(32'hFFFF_FFFF / NUM_SPANS);
  localparam logic [31:0]         LAST_BEFORE_WRAP = 32'hFFFF_FFF8;
  localparam logic [7:0]          ZERO_BYTE = 8'h00;
  localparam logic [7:0]          ONES_BYTE = 8'hFF;

  localparam logic CMD_FEED = 1'b0;
  localparam logic CMD_READ = 1'b1;

  localparam logic CFG_TOTAL_LOW  = 1'b0;
  localparam logic CFG_TOTAL_HIGH = 1'b1;

  typedef enum logic [2:0] {
    BANK_LAG      = 3'd0,
    BANK_COLUMN   = 3'd1,
    BANK_SPAN_POP = 3'd2,
    BANK_SPAN_ZER = 3'd3,
    BANK_SPAN_ONE = 3'd4,
    BANK_BITS_LO  = 3'd5,
    BANK_BITS_HI  = 3'd6,
    BANK_COL_BASE = 3'd7
  } bank_t;

  typedef enum logic [3:0] {
    ST_CLR,
    ST_IDLE,
    ST_LAG,
    ST_LAG_END,
    ST_COL_PH,
    ST_COL_LD,
    ST_COL_RD,
    ST_COL_WR,
    ST_COL_PW,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_SPAN_RD,
    ST_SPAN_WR,
    ST_FIN,
    ST_RD_A,
    ST_RD_B
  } st_t;

  localparam logic [2:0] NIB_POP [16] = '{
    3'd0, 3'd1, 3'd1, 3'd2, 3'd1, 3'd2, 3'd2, 3'd3,
    3'd1, 3'd2, 3'd2, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4
  };

  function automatic logic [3:0] pop8(input logic [7:0] v);
    pop8 = 4'(NIB_POP[v[3:0]]) + 4'(NIB_POP[v[7:4]]);
  endfunction

endpackage
`default_nettype wire

[rtl/bsbs_div.sv]
// Radix-2 restoring divider: one quotient bit per cycle.
`default_nettype none
module bsbs_div
  import bsbs_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire logic [31:0]         dividend,
  input  wire logic [STRIDE_W-1:0] divisor,
  output logic                     done,
  output logic [31:0]              quotient
);

  logic [31:0]         q_r;
  logic [STRIDE_W-1:0] rem_r;
  logic [5:0]          cnt_r;
  logic                busy_r;
  logic                done_r;
  logic [STRIDE_W:0]   trial;
  logic                fits;

  assign trial = {rem_r, q_r[31]};
  assign fits  = trial >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 6'd1;
        if (cnt_r == 6'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift the dividend out of the top while quotient bits enter at the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[30:0], fits};
      rem_r <= fits ? STRIDE_W'(trial - {1'b0, divisor}) : trial[STRIDE_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = q_r;

endmodule
`default_nettype wire

[rtl/byte_stream_bit_statistics_unit.sv]
// Top level of the byte stream bit statistics unit: sequencer, counter memories, read port.
//
// Input beats (in_*): in_tuser is the command, 0 feeds in_tdata[7:0] as one data
// byte, 1 reads one counter chosen by bank in_tdata[10:8] and index in_tdata[25:11].
// Only a read produces an output beat: out_tdata is the counter value, out_tuser is
// 1 when the index lies inside the bank (the value is 0 otherwise).
// Configuration (cfg_*): cfg_addr 0 is the low and 1 the high word of the expected
// stream size in bits; the span stride is derived from them, write only while idle.
// The block works on one beat at a time and holds in_tready low meanwhile.
// A feed walks the lag counters over the history, then goes one width at a time
// through the column counters with one read-modify-write per set bit, then runs
// the span divider. A read passes the states ST_RD_A and ST_RD_B before its result
// is registered for the output beat.
// After reset a clearing pass walks all memories once with in_tready low;
// configuration writes are taken during the pass.
// When the receiver stalls, the finished read result waits in the output
// register; feeds go on, and a following read holds in its read state, with
// in_tready low, until that beat is taken.
`default_nettype none
module byte_stream_bit_statistics_unit
  import bsbs_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // data_byte[7:0], bank[10:8], index[25:11], zero fill
  input  wire logic        in_tuser,   // cmd
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata,  // read_value[31:0]
  output logic             out_tuser,  // index_valid
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [31:0] cfg_wdata
);

  st_t state_r, state_nxt;

  logic [COL_AW-1:0]  cnt_r;
  logic [7:0]         w_r, p_r, p_inc;
  logic [2:0]         k_r;
  logic [COL_AW-1:0]  base_r;
  logic [7:0]         byte_r;
  logic [2:0]         bank_r;
  logic [14:0]        idx_r;
  logic [HIST_AW-1:0] hp_r;
  logic [31:0]        bcl_r, bch_r;
  logic [SPAN_AW-1:0] span_r;
  logic               lag_wv_r;
  logic [HIST_AW-1:0] lag_wa_r;
  logic               out_valid_r, out_iv_r;
  logic [31:0]        out_data_r;
  logic [31:0]        tbl_r, tbh_r;
  logic [STRIDE_W-1:0] stride;
  logic               out_free;
  logic               clr_last;

  // memories
  logic [7:0]  hist_mem [HIST_DEPTH];
  logic [31:0] lag_mem  [HIST_DEPTH];
  logic [31:0] col_mem  [COL_TOTAL];
  logic [31:0] spp_mem  [NUM_SPANS];
  logic [31:0] spz_mem  [NUM_SPANS];
  logic [31:0] spo_mem  [NUM_SPANS];
  logic [7:0]  ph_mem   [MAX_WIDTH];

  logic [7:0]  hist_rd_r;
  logic [31:0] lag_rd_r, col_rd_r, spp_rd_r, spz_rd_r, spo_rd_r;
  logic [7:0]  ph_rd_r;

  logic               hist_we, lag_we, col_we, sp_we, ph_we;
  logic [HIST_AW-1:0] hist_wa, hist_ra, lag_wa, lag_ra;
  logic [7:0]         hist_wd, ph_wd;
  logic [31:0]        lag_wd, col_wd, spp_wd, spz_wd, spo_wd;
  logic [COL_AW-1:0]  col_wa, col_ra;
  logic [SPAN_AW-1:0] sp_wa, sp_ra;
  logic [PH_AW-1:0]   ph_wa, ph_ra;

  logic                div_start;
  logic                div_done;
  logic [31:0]         quotient;
  logic [15:0]         base_prod;
  logic [31:0]         base_val;
  logic                rd_valid;
  logic [31:0]         rd_value;

  // stride: coarse fixed value when the size has a high word, else low / spans, at least 1
  always_comb begin
    if (tbh_r != 32'd0) stride = WIDE_STRIDE;
    else if (tbl_r[31:SPAN_AW] == '0) stride = STRIDE_W'(1);
    else stride = STRIDE_W'(tbl_r >> SPAN_AW);
  end

  assign p_inc    = (p_r + 8'd1 == w_r) ? 8'd0 : p_r + 8'd1;
  assign out_free = !out_valid_r || out_tready;
  assign clr_last = cnt_r == COL_AW'(COL_TOTAL - 1);

  bsbs_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (bcl_r),
    .divisor  (stride),
    .done     (div_done),
    .quotient (quotient)
  );

  // read path value for the selected bank
  assign base_prod = 16'(idx_r[7:0]) * 16'(idx_r[7:0] - 8'd1);
  assign base_val  = (idx_r[7:0] <= 8'(MIN_WIDTH)) ? 32'd0
                   : 32'(base_prod[15:1]) - 32'(((MIN_WIDTH - 1) * MIN_WIDTH) / 2);

  always_comb begin
    rd_valid = 1'b0;
    rd_value = 32'd0;
    case (bank_t'(bank_r))
      BANK_LAG: begin
        rd_valid = idx_r < 15'(HIST_DEPTH);
        rd_value = lag_rd_r;
      end
      BANK_COLUMN: begin
        rd_valid = idx_r < 15'(COL_TOTAL);
        rd_value = col_rd_r;
      end
      BANK_SPAN_POP: begin
        rd_valid = idx_r < 15'(NUM_SPANS);
        rd_value = spp_rd_r;
      end
      BANK_SPAN_ZER: begin
        rd_valid = idx_r < 15'(NUM_SPANS);
        rd_value = spz_rd_r;
      end
      BANK_SPAN_ONE: begin
        rd_valid = idx_r < 15'(NUM_SPANS);
        rd_value = spo_rd_r;
      end
      BANK_BITS_LO: begin
        rd_valid = idx_r == 15'd0;
        rd_value = bcl_r;
      end
      BANK_BITS_HI: begin
        rd_valid = idx_r == 15'd0;
        rd_value = bch_r;
      end
      BANK_COL_BASE: begin
        rd_valid = idx_r < 15'(MAX_WIDTH);
        rd_value = base_val;
      end
      default: begin
        rd_valid = 1'b0;
        rd_value = 32'd0;
      end
    endcase
  end

  // next state and memory port control
  always_comb begin
    state_nxt = state_r;
    div_start = 1'b0;
    hist_we = 1'b0;  hist_wa = hp_r;  hist_wd = byte_r;
    hist_ra = HIST_AW'(hp_r - cnt_r[HIST_AW-1:0] - HIST_AW'(1));
    lag_we  = lag_wv_r;  lag_wa = lag_wa_r;
    lag_wd  = lag_rd_r + 32'(pop8(byte_r ^ hist_rd_r));
    lag_ra  = cnt_r[HIST_AW-1:0];
    col_we  = 1'b0;  col_wa = base_r + COL_AW'(p_r);  col_wd = col_rd_r + 32'd1;
    col_ra  = base_r + COL_AW'(p_r);
    sp_we   = 1'b0;  sp_wa = span_r;  sp_ra = span_r;
    spp_wd  = spp_rd_r + 32'(pop8(byte_r));
    spz_wd  = spz_rd_r + 32'(byte_r == ZERO_BYTE);
    spo_wd  = spo_rd_r + 32'(byte_r == ONES_BYTE);
    ph_we   = 1'b0;  ph_wa = PH_AW'(w_r - 8'(MIN_WIDTH));  ph_ra = ph_wa;
    ph_wd   = (bcl_r == LAST_BEFORE_WRAP) ? 8'd0 : p_r;

    case (state_r)
      ST_CLR: begin
        col_we = 1'b1;  col_wa = cnt_r;  col_wd = 32'd0;
        if (cnt_r < COL_AW'(HIST_DEPTH)) begin
          hist_we = 1'b1;  hist_wa = cnt_r[HIST_AW-1:0];  hist_wd = 8'd0;
          lag_we  = 1'b1;  lag_wa  = cnt_r[HIST_AW-1:0];  lag_wd  = 32'd0;
        end
        if (cnt_r < COL_AW'(NUM_SPANS)) begin
          sp_we  = 1'b1;  sp_wa = cnt_r[SPAN_AW-1:0];
          spp_wd = 32'd0; spz_wd = 32'd0; spo_wd = 32'd0;
        end
        if (cnt_r < COL_AW'(MAX_WIDTH)) begin
          ph_we = 1'b1;  ph_wa = cnt_r[PH_AW-1:0];  ph_wd = 8'd0;
        end
        if (clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_tvalid) state_nxt = (in_tuser == CMD_READ) ? ST_RD_A : ST_LAG;
      end
      ST_LAG: begin
        if (cnt_r == COL_AW'(HIST_DEPTH - 1)) state_nxt = ST_LAG_END;
      end
      ST_LAG_END: state_nxt = ST_COL_PH;
      ST_COL_PH:  state_nxt = ST_COL_LD;
      ST_COL_LD:  state_nxt = ST_COL_RD;
      ST_COL_RD: begin
        if (byte_r[k_r]) state_nxt = ST_COL_WR;
        else if (k_r == 3'd7) state_nxt = ST_COL_PW;
      end
      ST_COL_WR: begin
        col_we    = 1'b1;
        state_nxt = (k_r == 3'd7) ? ST_COL_PW : ST_COL_RD;
      end
      ST_COL_PW: begin
        ph_we     = 1'b1;
        state_nxt = (w_r == 8'(MAX_WIDTH - 1)) ? ST_DIV_GO : ST_COL_PH;
      end
      ST_DIV_GO: begin
        div_start = 1'b1;
        state_nxt = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: if (div_done) state_nxt = ST_SPAN_RD;
      ST_SPAN_RD:  state_nxt = ST_SPAN_WR;
      ST_SPAN_WR: begin
        sp_we     = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_FIN: begin
        hist_we   = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_RD_A: begin
        lag_ra    = idx_r[HIST_AW-1:0];
        col_ra    = idx_r[COL_AW-1:0];
        sp_ra     = idx_r[SPAN_AW-1:0];
        state_nxt = ST_RD_B;
      end
      ST_RD_B: begin
        // hold the read addresses so the data stays put while the output is busy
        lag_ra = idx_r[HIST_AW-1:0];
        col_ra = idx_r[COL_AW-1:0];
        sp_ra  = idx_r[SPAN_AW-1:0];
        if (out_free) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_CLR;
    else state_r <= state_nxt;
  end

  // sequencer counters and feed state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      hp_r        <= '0;
      bcl_r       <= '0;
      bch_r       <= '0;
      lag_wv_r    <= 1'b0;
      out_valid_r <= 1'b0;
      tbl_r       <= '0;
      tbh_r       <= '0;
    end else begin
      lag_wv_r <= state_r == ST_LAG;
      if (cfg_we) begin
        if (cfg_addr == CFG_TOTAL_LOW) tbl_r <= cfg_wdata;
        if (cfg_addr == CFG_TOTAL_HIGH) tbh_r <= cfg_wdata;
      end
      if (state_r == ST_RD_B && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
      case (state_r)
        ST_CLR:  cnt_r <= cnt_r + COL_AW'(1);
        ST_IDLE: cnt_r <= '0;
        ST_LAG:  cnt_r <= cnt_r + COL_AW'(1);
        ST_FIN: begin
          hp_r  <= hp_r + HIST_AW'(1);
          bcl_r <= bcl_r + 32'd8;
          if (bcl_r > LAST_BEFORE_WRAP - 32'd1) bch_r <= bch_r + 32'd1;
        end
        default: ;
      endcase
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lag_wa_r <= cnt_r[HIST_AW-1:0];
    case (state_r)
      ST_IDLE: begin
        byte_r <= in_tdata[7:0];
        bank_r <= in_tdata[10:8];
        idx_r  <= in_tdata[25:11];
        w_r    <= 8'(MIN_WIDTH);
        base_r <= '0;
      end
      ST_COL_LD: begin
        p_r <= ph_rd_r;
        k_r <= '0;
      end
      ST_COL_RD: begin
        if (!byte_r[k_r]) begin
          p_r <= p_inc;
          k_r <= k_r + 3'd1;
        end
      end
      ST_COL_WR: begin
        p_r <= p_inc;
        k_r <= k_r + 3'd1;
      end
      ST_COL_PW: begin
        base_r <= base_r + COL_AW'(w_r);
        w_r    <= w_r + 8'd1;
      end
      ST_DIV_WAIT: begin
        span_r <= (quotient >= 32'(NUM_SPANS)) ? SPAN_AW'(NUM_SPANS - 1)
                                                : quotient[SPAN_AW-1:0];
      end
      ST_RD_B: begin
        if (out_free) begin
          out_data_r <= rd_valid ? rd_value : 32'd0;
          out_iv_r   <= rd_valid;
        end
      end
      default: ;
    endcase
  end

  // memories: one write and one registered read port each
  always_ff @(posedge clk) begin
    if (hist_we) hist_mem[hist_wa] <= hist_wd;
    hist_rd_r <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (lag_we) lag_mem[lag_wa] <= lag_wd;
    lag_rd_r <= lag_mem[lag_ra];
  end

  always_ff @(posedge clk) begin
    if (col_we) col_mem[col_wa] <= col_wd;
    col_rd_r <= col_mem[col_ra];
  end

  always_ff @(posedge clk) begin
    if (sp_we) begin
      spp_mem[sp_wa] <= spp_wd;
      spz_mem[sp_wa] <= spz_wd;
      spo_mem[sp_wa] <= spo_wd;
    end
    spp_rd_r <= spp_mem[sp_ra];
    spz_rd_r <= spz_mem[sp_ra];
    spo_rd_r <= spo_mem[sp_ra];
  end

  always_ff @(posedge clk) begin
    if (ph_we) ph_mem[ph_wa] <= ph_wd;
    ph_rd_r <= ph_mem[ph_ra];
  end

  assign in_tready  = state_r == ST_IDLE;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_iv_r;

  a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata == 32'd0))
    else $error("invalid read index returned nonzero value");

  a_lag_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_LAG) |-> (cnt_r < COL_AW'(HIST_DEPTH)))
    else $error("lag walk ran past history depth");

  a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_COL_RD) |-> (p_r < w_r))
    else $error("column phase not reduced below width");

  a_hp_advance: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN) |=> (hp_r == HIST_AW'($past(hp_r) + HIST_AW'(1))))
    else $error("history pointer did not advance after feed");

endmodule
`default_nettype wire

[tb/tb_byte_stream_bit_statistics_unit.sv]
// Self-checking testbench for the byte stream bit statistics unit.
`timescale 1ns / 1ps
module tb_byte_stream_bit_statistics_unit
  import bsbs_pkg::*;
;

  // Clock, reset and DUT ports
  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // data_byte[7:0], bank[10:8], index[25:11], zero fill
  logic        in_tuser;   // cmd
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // read_value[31:0]
  logic        out_tuser;  // index_valid
  logic        cfg_we;
  logic        cfg_addr;
  logic [31:0] cfg_wdata;

  byte_stream_bit_statistics_unit i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tuser(in_tuser),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Mirror of the block's statistics state
  logic [7:0]  hist_bytes [HIST_DEPTH];
  int unsigned hist_ptr;
  logic [31:0] lag_sum [HIST_DEPTH];
  logic [31:0] col_cnt [COL_TOTAL];
  logic [31:0] pop_by_span [NUM_SPANS];
  logic [31:0] zeros_by_span [NUM_SPANS];
  logic [31:0] ones_by_span [NUM_SPANS];
  logic [31:0] bits_lo;
  logic [31:0] bits_hi;
  logic [31:0] size_lo;
  logic [31:0] size_hi;
  logic [31:0] stride;
  logic [31:0] width_base [MAX_WIDTH];

  // Pending read results, oldest first
  typedef struct packed {
    logic [31:0] value;
    logic        ok;
  } read_beat_t;
  read_beat_t pending_reads [$];

  int errors;
  int n_feeds;
  int n_reads;
  int n_invalid;
  int snd_pct;
  int rcv_pct;
  int rx_hold;

  function automatic int bank_size(input bank_t b);
    case (b) inside
      BANK_LAG:                                    return HIST_DEPTH;
      BANK_COLUMN:                                 return COL_TOTAL;
      BANK_SPAN_POP, BANK_SPAN_ZER, BANK_SPAN_ONE: return NUM_SPANS;
      BANK_BITS_LO, BANK_BITS_HI:                  return 1;
      default:                                     return MAX_WIDTH;
    endcase
  endfunction

  function automatic int ones_in(input logic [7:0] v);
    int c;
    c = 0;
    for (int i = 0; i < 8; i++) c += v[i];
    return c;
  endfunction

  function automatic void update_stride();
    if (size_hi != 0) stride = 32'hFFFF_FFFF / NUM_SPANS;
    else stride = size_lo / NUM_SPANS;
    if (stride == 0) stride = 1;
  endfunction

  // Apply one data byte to the mirrored counters
  function automatic void absorb_byte(input logic [7:0] b);
    logic [31:0] span;
    for (int lag = 1; lag <= HIST_DEPTH; lag++)
      lag_sum[lag-1] += ones_in(b ^ hist_bytes[(hist_ptr + HIST_DEPTH - lag) % HIST_DEPTH]);
    for (int w = MIN_WIDTH; w < MAX_WIDTH; w++)
      for (int k = 0; k < 8; k++)
        if (b[k]) col_cnt[width_base[w] + int'((bits_lo + k) % w)] += 1;
    span = bits_lo / stride;
    if (span >= NUM_SPANS) span = NUM_SPANS - 1;
    pop_by_span[span] += ones_in(b);
    if (b == ZERO_BYTE) zeros_by_span[span] += 1;
    if (b == ONES_BYTE) ones_by_span[span] += 1;
    hist_bytes[hist_ptr] = b;
    hist_ptr = (hist_ptr + 1) % HIST_DEPTH;
    if (bits_lo > 32'hFFFF_FFF7) bits_hi += 1;
    bits_lo += 8;
  endfunction

  function automatic read_beat_t lookup_counter(input bank_t b, input int idx);
    read_beat_t r;
    r.ok = (idx < bank_size(b));
    r.value = '0;
    if (r.ok) begin
      case (b)
        BANK_LAG:      r.value = lag_sum[idx];
        BANK_COLUMN:   r.value = col_cnt[idx];
        BANK_SPAN_POP: r.value = pop_by_span[idx];
        BANK_SPAN_ZER: r.value = zeros_by_span[idx];
        BANK_SPAN_ONE: r.value = ones_by_span[idx];
        BANK_BITS_LO:  r.value = bits_lo;
        BANK_BITS_HI:  r.value = bits_hi;
        default:       r.value = width_base[idx];
      endcase
    end
    return r;
  endfunction

  // Write one size register; the block must be idle
  task automatic write_size(input logic addr, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (addr == CFG_TOTAL_LOW) size_lo = val;
    else size_hi = val;
    update_stride();
    @(negedge clk);
  endtask

  // Offer one beat (called at a falling edge), return at the falling edge after acceptance
  task automatic send_beat(input logic cmd, input logic [7:0] db, input bank_t b,
                           input logic [14:0] idx, input bit typed, input read_beat_t typed_r);
    int gap;
    gap = ($urandom_range(99) < snd_pct) ? $urandom_range(1, 4) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= cmd;
    in_tdata  <= {6'b0, idx, b, db};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    if (cmd == CMD_FEED) begin
      absorb_byte(db);
      n_feeds++;
    end else begin
      pending_reads.push_back(typed ? typed_r : lookup_counter(b, idx));
      n_reads++;
      if (idx >= bank_size(b)) n_invalid++;
    end
    @(negedge clk);
  endtask

  // Random beat: mostly reads, spread over valid, boundary and arbitrary indexes
  task automatic send_random();
    bank_t b;
    logic [14:0] idx;
    read_beat_t none;
    none = '0;
    b = bank_t'($urandom_range(7));
    case ($urandom_range(9)) inside
      [0:2]:    idx = 15'($urandom_range(bank_size(b) - 1));
      [3:4]:    idx = 15'($urandom_range((bank_size(b) < 800 ? bank_size(b) : 800) - 1));
      5:        idx = 15'(bank_size(b));
      6:        idx = 15'(bank_size(b) - 1);
      default:  idx = 15'($urandom_range(32767));
    endcase
    if ($urandom_range(99) < 30)
      send_beat(CMD_FEED, 8'($urandom_range(255)), b, idx, 1'b0, none);
    else
      send_beat(CMD_READ, 8'($urandom_range(255)), b, idx, 1'b0, none);
  endtask

  // Wait for all reads to return, then let a possible feed run out
  task automatic drain();
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (6000) @(negedge clk);
  endtask

  // Directed rows; typed expectations only where obvious from reset or bank bounds
  typedef struct {
    logic        cmd;
    logic [7:0]  db;
    bank_t       b;
    logic [14:0] idx;
    bit          typed;
    logic [31:0] value;
    logic        ok;
  } row_t;

  row_t rows [] = '{
    '{CMD_READ, 8'h00, BANK_LAG,      15'd0,     1, 32'd0,     1'b1},
    '{CMD_READ, 8'h00, BANK_LAG,      15'd511,   1, 32'd0,     1'b1},
    '{CMD_READ, 8'h00, BANK_LAG,      15'd512,   1, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_COLUMN,   15'd32636, 1, 32'd0,     1'b1},
    '{CMD_READ, 8'h00, BANK_COLUMN,   15'd32637, 1, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_SPAN_POP, 15'd4096,  1, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_BITS_LO,  15'd1,     1, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_BITS_HI,  15'd0,     1, 32'd0,     1'b1},
    '{CMD_READ, 8'h00, BANK_COL_BASE, 15'd3,     1, 32'd0,     1'b1},
    '{CMD_READ, 8'h00, BANK_COL_BASE, 15'd4,     1, 32'd3,     1'b1},
    '{CMD_READ, 8'h00, BANK_COL_BASE, 15'd255,   1, 32'd32382, 1'b1},
    '{CMD_READ, 8'h00, BANK_COL_BASE, 15'd256,   1, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_SPAN_ONE, 15'd32767, 1, 32'd0,     1'b0},
    // early feeds see a cleared history
    '{CMD_FEED, 8'h00, BANK_LAG,      15'd0,     0, 32'd0,     1'b0},
    '{CMD_FEED, 8'hFF, BANK_COL_BASE, 15'd32767, 0, 32'd0,     1'b0},
    '{CMD_FEED, 8'hA5, BANK_LAG,      15'd0,     0, 32'd0,     1'b0},
    '{CMD_FEED, 8'h5A, BANK_LAG,      15'd0,     0, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_LAG,      15'd0,     0, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_LAG,      15'd3,     0, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_COLUMN,   15'd0,     0, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_SPAN_POP, 15'd8,     0, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_SPAN_ZER, 15'd0,     0, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_SPAN_ONE, 15'd8,     0, 32'd0,     1'b0},
    '{CMD_READ, 8'h00, BANK_BITS_LO,  15'd0,     0, 32'd0,     1'b0}
  };

  // Receiver: random stall, or a counted long hold-off when requested
  initial begin
    out_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_tready <= 1'b0;
        rx_hold--;
      end else begin
        out_tready <= ($urandom_range(99) >= rcv_pct);
      end
    end
  end

  // Compare each returned beat with the oldest pending read
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_reads.size() == 0) begin
        $display("%0t: unexpected output beat value=%h valid=%b", $time, out_tdata, out_tuser);
        errors++;
      end else begin
        read_beat_t e;
        e = pending_reads.pop_front();
        if (out_tdata !== e.value) begin
          $display("%0t: read_value expected %h actual %h", $time, e.value, out_tdata);
          errors++;
        end
        if (out_tuser !== e.ok) begin
          $display("%0t: index_valid expected %b actual %b", $time, e.ok, out_tuser);
          errors++;
        end
      end
    end
  end

  // Hard limit: clearing pass plus every beat as a slowest feed, several times over
  initial begin
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

  initial begin
    read_beat_t tr;
    rst_n     = 1'b0;
    in_tvalid = 1'b0;
    in_tdata  = '0;
    in_tuser  = 1'b0;
    cfg_we    = 1'b0;
    cfg_addr  = 1'b0;
    cfg_wdata = '0;
    errors = 0; n_feeds = 0; n_reads = 0; n_invalid = 0;
    snd_pct = 0; rcv_pct = 0; rx_hold = 0;
    hist_ptr = 0; bits_lo = '0; bits_hi = '0; size_lo = '0; size_hi = '0;
    foreach (hist_bytes[i]) hist_bytes[i] = '0;
    foreach (lag_sum[i]) lag_sum[i] = '0;
    foreach (col_cnt[i]) col_cnt[i] = '0;
    foreach (pop_by_span[i]) begin
      pop_by_span[i] = '0; zeros_by_span[i] = '0; ones_by_span[i] = '0;
    end
    width_base[0] = 0;
    for (int w = 1; w < MAX_WIDTH; w++)
      width_base[w] = (w <= MIN_WIDTH) ? 0 : width_base[w-1] + (w - 1);
    update_stride();

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Smallest stride: both size words zero
    write_size(CFG_TOTAL_LOW, 32'h0);
    write_size(CFG_TOTAL_HIGH, 32'h0);

    // Directed rows, no idling
    foreach (rows[i]) begin
      tr.value = rows[i].value;
      tr.ok    = rows[i].ok;
      send_beat(rows[i].cmd, rows[i].db, rows[i].b, rows[i].idx, rows[i].typed, tr);
    end
    drain();

    // Moderate stride, sender idling
    write_size(CFG_TOTAL_LOW, 32'd16384);
    snd_pct = 48; rcv_pct = 0;
    repeat (66) send_random();
    drain();

    // Largest low word alone, receiver stalling
    write_size(CFG_TOTAL_LOW, 32'hFFFF_FFFF);
    snd_pct = 0; rcv_pct = 48;
    repeat (66) send_random();
    drain();

    // Nonzero high word selects the fixed stride, both sides idling a little
    write_size(CFG_TOTAL_HIGH, 32'hFFFF_FFFF);
    snd_pct = 7; rcv_pct = 7;
    repeat (40) send_random();
    // pause the sender until every pending read is back
    in_tvalid <= 1'b0;
    while (pending_reads.size() != 0) @(negedge clk);
    repeat (26) send_random();
    drain();

    // Back to the low word only, no idling; hold the receiver off while reads pile up
    write_size(CFG_TOTAL_HIGH, 32'h0);
    write_size(CFG_TOTAL_LOW, 32'd40000);
    snd_pct = 0; rcv_pct = 0;
    rx_hold = 300;
    for (int i = 0; i < 8; i++)
      send_beat(CMD_READ, 8'h00, BANK_BITS_LO, 15'd0, 1'b0, tr);
    repeat (62) send_random();
    in_tvalid <= 1'b0;

    while (pending_reads.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
    $display("Covered %0d feeds and %0d reads (%0d outside their bank) over five size settings.",
             n_feeds, n_reads, n_invalid);
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[files.f]
rtl/bsbs_pkg.sv
rtl/bsbs_div.sv
rtl/byte_stream_bit_statistics_unit.sv
tb/tb_byte_stream_bit_statistics_unit.sv
